// ===== hw/rtl/fvc_pkg.sv =====
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared types, constants and helpers of the frustum volume culling block.
// ----------------------------------------------------------------------------
`default_nettype none

package fvc_pkg;

  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned BASE_PLANES = 6;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CFG_REGS    = 8;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned IN_DATA_W   = 224;
  localparam int unsigned OUT_DATA_W  = 8;
  localparam int unsigned RADIUS_W    = 31;

  localparam logic [CFG_W-1:0] CFG_RESET [CFG_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [3:0] plane_t;
  typedef word_t [2:0] vec3_t;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE   = 2'd0,
    VERDICT_INSIDE    = 2'd1,
    VERDICT_INTERSECT = 2'd2
  } verdict_e;

  typedef enum logic {
    CMD_SPHERE = 1'b0,
    CMD_BOX    = 1'b1
  } cmd_e;

  // matrix row used by base plane j
  function automatic logic [1:0] plane_row(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      3'd4, 3'd5: r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  // base plane j subtracts its row
  function automatic logic plane_neg(input logic [2:0] j);
    logic n;
    case (j)
      3'd0, 3'd3, 3'd4: n = 1'b1;
      default:          n = 1'b0;
    endcase
    return n;
  endfunction

  function automatic word_t sat32(input logic signed [WORD_W+1:0] v);
    word_t r;
    if (v[WORD_W+1:WORD_W-1] == 3'b000 || v[WORD_W+1:WORD_W-1] == 3'b111) begin
      r = word_t'(v[WORD_W-1:0]);
    end else if (v[WORD_W+1]) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fvc_plane_builder.sv =====
// ----------------------------------------------------------------------------
// fvc_plane_builder
// Matrix registers and plane rebuild sequencer: square sum, bit-serial
// square root and restoring divider, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fvc_plane_builder #(
  parameter int unsigned PLANE_COUNT = fvc_pkg::PLANE_COUNT,
  parameter int unsigned FRAC_BITS   = fvc_pkg::FRAC_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [fvc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [fvc_pkg::CFG_W-1:0]            cfg_data_i,
  output logic                                      busy_o,
  output fvc_pkg::plane_t [PLANE_COUNT-1:0]         planes_o
);

  localparam int unsigned KW  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int unsigned NW  = fvc_pkg::WORD_W + FRAC_BITS;
  localparam int unsigned CW  = $clog2(NW + 1);
  localparam int unsigned WW  = fvc_pkg::WORD_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SQ    = 6'b000010,
    S_SQRT  = 6'b000100,
    S_DLOAD = 6'b001000,
    S_DIV   = 6'b010000,
    S_DWR   = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [fvc_pkg::CFG_W-1:0]     cfg_q [fvc_pkg::CFG_REGS];
  logic [KW-1:0]                 k_q, k_d;
  logic [1:0]                    c_q, c_d;
  logic [63:0]                   acc_q, acc_d;
  logic [63:0]                   sq_q, sq_d;
  logic [63:0]                   res_q, res_d;
  logic [63:0]                   bit_q, bit_d;
  logic [NW-1:0]                 num_q, num_d;
  logic [WW-1:0]                 rem_q, rem_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  fvc_pkg::plane_t [PLANE_COUNT-1:0] planes_q;

  logic                          cfg_hit;
  logic [2:0]                    kk, jj;
  logic [1:0]                    row;
  logic [fvc_pkg::CFG_W-1:0]     reg3, regr;
  fvc_pkg::word_t                e3, er, comp;
  logic signed [WW+1:0]          raw;
  logic signed [63:0]            sq_prod;
  logic [WW-1:0]                 mag, len;
  logic [63:0]                   sqrt_t;
  logic [WW:0]                   r2;
  logic                          dge;
  fvc_pkg::word_t                div_val, wval;
  logic                          we;

  assign cfg_hit = cfg_we_i && (cfg_idx_i < fvc_pkg::CFG_IDX_W'(fvc_pkg::CFG_REGS));

  always_comb begin
    kk   = 3'(k_q);
    jj   = (kk >= 3'(fvc_pkg::BASE_PLANES)) ? kk - 3'(fvc_pkg::BASE_PLANES) : kk;
    row  = fvc_pkg::plane_row(jj);
    reg3 = cfg_q[{c_q, 1'b1}];
    regr = cfg_q[{c_q, row[1]}];
    e3   = fvc_pkg::word_t'(reg3[63:32]);
    er   = row[0] ? fvc_pkg::word_t'(regr[63:32]) : fvc_pkg::word_t'(regr[31:0]);
    if (fvc_pkg::plane_neg(jj)) begin
      raw = (WW+2)'(e3) - (WW+2)'(er);
    end else begin
      raw = (WW+2)'(e3) + (WW+2)'(er);
    end
    comp    = fvc_pkg::sat32(raw);
    sq_prod = $signed(comp) * $signed(comp);
    mag     = comp[WW-1] ? (~comp + 1'b1) : comp;
    len     = res_q[WW-1:0];
    sqrt_t  = res_q + bit_q;
    r2      = {rem_q, num_q[NW-1]};
    dge     = r2 >= {1'b0, len};
    // quotient back to a signed word with saturation
    if (!comp[WW-1]) begin
      div_val = (|num_q[NW-1:WW-1]) ? {1'b0, {(WW-1){1'b1}}} : num_q[WW-1:0];
    end else if ((|num_q[NW-1:WW]) || (num_q[WW-1] && (|num_q[WW-2:0]))) begin
      div_val = {1'b1, {(WW-1){1'b0}}};
    end else begin
      div_val = ~num_q[WW-1:0] + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    c_d     = c_q;
    acc_d   = acc_q;
    sq_d    = sq_q;
    res_d   = res_q;
    bit_d   = bit_q;
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    we      = 1'b0;
    wval    = comp;
    case (state_q)
      S_IDLE: ;
      S_SQ: begin
        acc_d = acc_q + sq_q;
        sq_d  = (c_q != 2'd3) ? 64'(sq_prod) : 64'd0;
        if (c_q == 2'd3) begin
          state_d = S_SQRT;
          res_d   = 64'd0;
          bit_d   = 64'd1 << 62;
          c_d     = 2'd0;
        end else begin
          c_d = c_q + 2'd1;
        end
      end
      S_SQRT: begin
        if (acc_q >= sqrt_t) begin
          acc_d = acc_q - sqrt_t;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) state_d = S_DLOAD;
      end
      S_DLOAD: begin
        if (len == '0) begin
          we      = 1'b1;
          state_d = S_DWR;
        end else begin
          num_d   = {mag, {FRAC_BITS{1'b0}}};
          rem_d   = '0;
          cnt_d   = CW'(NW);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = dge ? WW'(r2 - {1'b0, len}) : r2[WW-1:0];
        num_d = {num_q[NW-2:0], dge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) state_d = S_DWR;
      end
      S_DWR: begin
        if (len != '0) begin
          we   = 1'b1;
          wval = div_val;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // advance to the next component or plane once a word is written
    if (state_q == S_DWR || (state_q == S_DLOAD && len == '0)) begin
      if (c_q == 2'd3) begin
        c_d = 2'd0;
        if (k_q == KW'(PLANE_COUNT - 1)) begin
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + 1'b1;
          acc_d   = '0;
          sq_d    = '0;
          state_d = S_SQ;
        end
      end else begin
        c_d     = c_q + 2'd1;
        state_d = S_DLOAD;
      end
    end
    if (cfg_hit) begin
      state_d = S_SQ;
      k_d     = '0;
      c_d     = 2'd0;
      acc_d   = '0;
      sq_d    = '0;
    end
  end

  // state_q == S_DLOAD with zero length writes immediately
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SQ;
      k_q     <= '0;
      c_q     <= 2'd0;
      acc_q   <= '0;
      sq_q    <= '0;
      res_q   <= '0;
      bit_q   <= '0;
      num_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      for (int i = 0; i < int'(fvc_pkg::CFG_REGS); i++) cfg_q[i] <= fvc_pkg::CFG_RESET[i];
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      c_q     <= c_d;
      acc_q   <= acc_d;
      sq_q    <= sq_d;
      res_q   <= res_d;
      bit_q   <= bit_d;
      num_q   <= num_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      if (cfg_hit) cfg_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we && !cfg_hit) planes_q[k_q][c_q] <= wval;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign planes_o = planes_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fvc_query_pipe.sv =====
// ----------------------------------------------------------------------------
// fvc_query_pipe
// Five-stage test pipeline: vertex select, products, partial sums,
// per-plane compare, verdict register.
// ----------------------------------------------------------------------------
`default_nettype none

module fvc_query_pipe #(
  parameter int unsigned PLANE_COUNT = fvc_pkg::PLANE_COUNT,
  parameter int unsigned FRAC_BITS   = fvc_pkg::FRAC_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire fvc_pkg::plane_t [PLANE_COUNT-1:0]    planes_i,
  input  wire logic                                 busy_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 box_i,
  input  wire fvc_pkg::vec3_t                       first_i,
  input  wire fvc_pkg::vec3_t                       second_i,
  input  wire logic [fvc_pkg::RADIUS_W-1:0]         radius_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output fvc_pkg::verdict_e                         verdict_o
);

  localparam int unsigned SW = 66;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic box1_q, box2_q, box3_q;
  logic [fvc_pkg::RADIUS_W-1:0] rad1_q, rad2_q;
  fvc_pkg::vec3_t [PLANE_COUNT-1:0] pos1_q, neg1_q, pos1_d, neg1_d;
  logic signed [63:0] pp2_q [PLANE_COUNT][3];
  logic signed [63:0] np2_q [PLANE_COUNT][3];
  logic signed [SW-1:0] hp0_q [PLANE_COUNT];
  logic signed [SW-1:0] hp1_q [PLANE_COUNT];
  logic signed [SW-1:0] hn0_q [PLANE_COUNT];
  logic signed [SW-1:0] hn1_q [PLANE_COUNT];
  logic signed [SW-1:0] radt;
  logic [PLANE_COUNT-1:0] out4_q, neg4_q, out4_d, neg4_d;
  fvc_pkg::verdict_e verdict_q, verdict_d;

  assign en          = !vo_q || out_ready_i;
  assign in_ready_o  = en && !busy_i;
  assign out_valid_o = vo_q;
  assign verdict_o   = verdict_q;

  always_comb begin
    for (int k = 0; k < int'(PLANE_COUNT); k++) begin
      for (int i = 0; i < 3; i++) begin
        if (box_i && ($signed(planes_i[k][i]) > 0)) begin
          pos1_d[k][i] = second_i[i];
          neg1_d[k][i] = first_i[i];
        end else begin
          pos1_d[k][i] = first_i[i];
          neg1_d[k][i] = second_i[i];
        end
      end
    end
  end

  assign radt = box2_q ? '0 : ($signed(SW'({1'b0, rad2_q})) <<< FRAC_BITS);

  always_comb begin
    for (int k = 0; k < int'(PLANE_COUNT); k++) begin
      out4_d[k] = box3_q ? ((hp0_q[k] + hp1_q[k]) < 0) : ((hp0_q[k] + hp1_q[k]) <= 0);
      neg4_d[k] = box3_q && ((hn0_q[k] + hn1_q[k]) < 0);
    end
    if (|out4_q) begin
      verdict_d = fvc_pkg::VERDICT_OUTSIDE;
    end else if (|neg4_q) begin
      verdict_d = fvc_pkg::VERDICT_INTERSECT;
    end else begin
      verdict_d = fvc_pkg::VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i && in_ready_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      box1_q    <= box_i;
      rad1_q    <= radius_i;
      pos1_q    <= pos1_d;
      neg1_q    <= neg1_d;
      box2_q    <= box1_q;
      rad2_q    <= rad1_q;
      box3_q    <= box2_q;
      out4_q    <= out4_d;
      neg4_q    <= neg4_d;
      verdict_q <= verdict_d;
      for (int k = 0; k < int'(PLANE_COUNT); k++) begin
        for (int i = 0; i < 3; i++) begin
          pp2_q[k][i] <= $signed(planes_i[k][i]) * $signed(pos1_q[k][i]);
          np2_q[k][i] <= $signed(planes_i[k][i]) * $signed(neg1_q[k][i]);
        end
        hp0_q[k] <= SW'(pp2_q[k][0]) + SW'(pp2_q[k][1]);
        hp1_q[k] <= SW'(pp2_q[k][2]) + ($signed(SW'($signed(planes_i[k][3]))) <<< FRAC_BITS)
                    + radt;
        hn0_q[k] <= SW'(np2_q[k][0]) + SW'(np2_q[k][1]);
        hn1_q[k] <= SW'(np2_q[k][2]) + ($signed(SW'($signed(planes_i[k][3]))) <<< FRAC_BITS);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/frustum_volume_culling.sv =====
// ----------------------------------------------------------------------------
// frustum_volume_culling
// Sphere and box culling against planes taken from a view-projection matrix.
// ----------------------------------------------------------------------------
// Queries stream through a five-stage pipeline at one per cycle while the output
// is not stalled and no plane rebuild is running. After reset and after every
// matrix write the planes are rebuilt by one shared sequencer (square sum,
// 32-step square root, then a restoring divide of 32+FRAC_BITS steps per
// component), during which s_axis_tready stays low.
`default_nettype none

module frustum_volume_culling #(
  parameter int unsigned PLANE_COUNT = fvc_pkg::PLANE_COUNT,
  parameter int unsigned FRAC_BITS   = fvc_pkg::FRAC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, sphere_radius
  input  wire logic [fvc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // verdict
  output logic [fvc_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  input  wire logic                               cfg_we_i,
  input  wire logic [fvc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [fvc_pkg::CFG_W-1:0]          cfg_data_i
);

  logic                              busy;
  fvc_pkg::plane_t [PLANE_COUNT-1:0] planes;
  fvc_pkg::vec3_t                    first, second;
  fvc_pkg::verdict_e                 verdict;

  assign first[0]  = s_axis_tdata[31:0];
  assign first[1]  = s_axis_tdata[63:32];
  assign first[2]  = s_axis_tdata[95:64];
  assign second[0] = s_axis_tdata[127:96];
  assign second[1] = s_axis_tdata[159:128];
  assign second[2] = s_axis_tdata[191:160];

  fvc_plane_builder #(
    .PLANE_COUNT (PLANE_COUNT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_builder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .planes_o   (planes)
  );

  fvc_query_pipe #(
    .PLANE_COUNT (PLANE_COUNT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .planes_i    (planes),
    .busy_i      (busy),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .box_i       (s_axis_tuser == fvc_pkg::CMD_BOX),
    .first_i     (first),
    .second_i    (second),
    .radius_i    (s_axis_tdata[222:192]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .verdict_o   (verdict)
  );

  assign m_axis_tdata = {6'b0, verdict};

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("request taken during plane rebuild");

  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i < fvc_pkg::CFG_IDX_W'(fvc_pkg::CFG_REGS))) |=> busy)
    else $error("matrix write did not start a rebuild");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == fvc_pkg::VERDICT_OUTSIDE ||
                       m_axis_tdata[1:0] == fvc_pkg::VERDICT_INSIDE ||
                       m_axis_tdata[1:0] == fvc_pkg::VERDICT_INTERSECT))
    else $error("bad verdict code");

endmodule

`default_nettype wire

// ===== bench/frustum_volume_culling_tb.sv =====
// ----------------------------------------------------------------------------
// frustum_volume_culling_tb
// Streams sphere and box queries through the culling block under several
// matrices and idle patterns, and checks every verdict against a predictor
// that rebuilds the normalized planes on each matrix write.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frustum_volume_culling_tb;

  localparam int ONE = 1 << fvc_pkg::FRAC_BITS;
  localparam int ROW_OF [6] = '{0, 0, 1, 1, 2, 2};
  localparam int SIGN_OF [6] = '{-1, 1, 1, -1, -1, 1};

  typedef struct {
    fvc_pkg::cmd_e  cmd;
    fvc_pkg::word_t lo [3];
    fvc_pkg::word_t hi [3];
    logic [30:0]    rad;
  } query_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [fvc_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [fvc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we_i;
  logic [fvc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [fvc_pkg::CFG_W-1:0] cfg_data_i;

  logic [63:0]       matrix_regs [fvc_pkg::CFG_REGS];
  fvc_pkg::word_t    plane_words [fvc_pkg::PLANE_COUNT][4];
  fvc_pkg::verdict_e verdict_q [$];
  int                fails = 0;
  int                tx_idle = 0;
  int                rx_idle = 0;
  bit                rx_hold = 1'b0;

  always #5 clk_i = ~clk_i;

  frustum_volume_culling dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // ---- plane predictor ----
  function automatic longint mat_at(int col, int row);
    logic [63:0] r;
    r = matrix_regs[col * 2 + row / 2];
    return (row % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  function automatic fvc_pkg::word_t clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return fvc_pkg::word_t'(v);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void rebuild_planes();
    fvc_pkg::word_t comp [4];
    longint unsigned sum, len, mag, quo;
    longint v;
    int j;
    for (int k = 0; k < fvc_pkg::PLANE_COUNT; k++) begin
      j = k % 6;
      for (int c = 0; c < 4; c++)
        comp[c] = clip32(mat_at(c, 3) + SIGN_OF[j] * mat_at(c, ROW_OF[j]));
      sum = 0;
      for (int c = 0; c < 3; c++) begin
        v = comp[c];
        sum += longint'(v * v);
      end
      len = root64(sum);
      for (int c = 0; c < 4; c++) begin
        if (len == 0) begin
          plane_words[k][c] = comp[c];
        end else begin
          v = comp[c];
          mag = (v < 0) ? -v : v;
          quo = (mag << fvc_pkg::FRAC_BITS) / len;
          plane_words[k][c] = clip32(v < 0 ? -longint'(quo) : longint'(quo));
        end
      end
    end
  endfunction

  function automatic logic signed [95:0] plane_dist(int k, fvc_pkg::word_t x,
                                                    fvc_pkg::word_t y, fvc_pkg::word_t z);
    logic signed [95:0] px, py, pz, pd, vx, vy, vz;
    px = plane_words[k][0]; py = plane_words[k][1];
    pz = plane_words[k][2]; pd = plane_words[k][3];
    vx = x; vy = y; vz = z;
    return px * vx + py * vy + pz * vz + pd * ONE;
  endfunction

  function automatic fvc_pkg::verdict_e cull_verdict(query_t q);
    logic signed [95:0] radq, pos, neg;
    logic [2:0] up;
    fvc_pkg::verdict_e v;
    v = fvc_pkg::VERDICT_INSIDE;
    if (q.cmd == fvc_pkg::CMD_SPHERE) begin
      radq = {65'd0, q.rad};
      radq = radq * ONE;
      for (int k = 0; k < fvc_pkg::PLANE_COUNT; k++)
        if (plane_dist(k, q.lo[0], q.lo[1], q.lo[2]) + radq <= 0)
          return fvc_pkg::VERDICT_OUTSIDE;
    end else begin
      for (int k = 0; k < fvc_pkg::PLANE_COUNT; k++) begin
        for (int a = 0; a < 3; a++) up[a] = plane_words[k][a] > 0;
        pos = plane_dist(k, up[0] ? q.hi[0] : q.lo[0], up[1] ? q.hi[1] : q.lo[1],
                         up[2] ? q.hi[2] : q.lo[2]);
        neg = plane_dist(k, up[0] ? q.lo[0] : q.hi[0], up[1] ? q.lo[1] : q.hi[1],
                         up[2] ? q.lo[2] : q.hi[2]);
        if (pos < 0) return fvc_pkg::VERDICT_OUTSIDE;
        if (neg < 0) v = fvc_pkg::VERDICT_INTERSECT;
      end
    end
    return v;
  endfunction

  // ---- receive side ----
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    fvc_pkg::verdict_e want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict %0d", m_axis_tdata[1:0]);
        fails++;
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[1:0] !== want) begin
          $error("verdict expected %0d actual %0d", want, m_axis_tdata[1:0]);
          fails++;
        end
      end
    end
  end

  // ---- send side ----
  task automatic send_query(query_t q);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.cmd;
    s_axis_tdata  <= {1'b0, q.rad, q.hi[2], q.hi[1], q.hi[0], q.lo[2], q.lo[1], q.lo[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    verdict_q.push_back(cull_verdict(q));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(int idx, logic [63:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= fvc_pkg::CFG_IDX_W'(idx);
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < fvc_pkg::CFG_REGS) begin
      matrix_regs[idx] = val;
      rebuild_planes();
    end
  endtask

  function automatic query_t mk_query(fvc_pkg::cmd_e cmd, int ax, int ay, int az,
                                      int bx, int by, int bz, int r);
    query_t q;
    q.cmd = cmd;
    q.lo = '{ax, ay, az};
    q.hi = '{bx, by, bz};
    q.rad = 31'(r);
    return q;
  endfunction

  function automatic fvc_pkg::word_t rand_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: case ($urandom_range(3))
           0: return 32'h7fffffff;
           1: return 32'h80000000;
           2: return 0;
           default: return -1;
         endcase
      default: return int'($urandom_range(2621440)) - 1310720;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    fvc_pkg::word_t t;
    q.cmd = fvc_pkg::cmd_e'($urandom_range(1));
    for (int a = 0; a < 3; a++) begin
      q.lo[a] = rand_coord();
      q.hi[a] = rand_coord();
      if ($urandom_range(9) != 0 && q.lo[a] > q.hi[a]) begin
        t = q.lo[a]; q.lo[a] = q.hi[a]; q.hi[a] = t;
      end
    end
    case ($urandom_range(5))
      0: q.rad = 31'($urandom);
      1: q.rad = '0;
      default: q.rad = 31'($urandom_range(ONE * 8));
    endcase
    return q;
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(7))
      0: return 0;
      1: return $urandom;
      default: return int'($urandom_range(1 << 19)) - (1 << 18);
    endcase
  endfunction

  task automatic load_matrix(bit random_m);
    for (int i = 0; i < fvc_pkg::CFG_REGS; i++)
      cfg_write(i, random_m ? {rand_elem(), rand_elem()} : fvc_pkg::CFG_RESET[i]);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_query(rand_query());
  endtask

  // ---- tests ----
  task automatic test_identity_planes();
    send_query(mk_query(fvc_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(fvc_pkg::CMD_SPHERE, -ONE, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(fvc_pkg::CMD_SPHERE, 2 * ONE, 0, 0, 0, 0, 0, ONE));
    send_query(mk_query(fvc_pkg::CMD_SPHERE, 2 * ONE, 0, 0, 0, 0, 0, ONE + 1));
    send_query(mk_query(fvc_pkg::CMD_SPHERE, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        0, 0, 0, 31'h7fffffff));
    send_query(mk_query(fvc_pkg::CMD_SPHERE, 32'h80000000, 0, 0, -1, -1, -1, 0));
    send_query(mk_query(fvc_pkg::CMD_BOX, -ONE / 2, -ONE / 2, -ONE / 2,
                        ONE / 2, ONE / 2, ONE / 2, 0));
    send_query(mk_query(fvc_pkg::CMD_BOX, 0, 0, 0, 2 * ONE, ONE / 2, ONE / 2, 0));
    send_query(mk_query(fvc_pkg::CMD_BOX, 3 * ONE, 0, 0, 4 * ONE, ONE, ONE, 0));
    send_query(mk_query(fvc_pkg::CMD_BOX, ONE / 2, ONE / 2, ONE / 2,
                        -ONE / 2, -ONE / 2, -ONE / 2, 0));
    send_query(mk_query(fvc_pkg::CMD_BOX, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff));
    send_query(mk_query(fvc_pkg::CMD_BOX, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0));
  endtask

  task automatic test_zero_normal();
    for (int i = 0; i < fvc_pkg::CFG_REGS; i++) cfg_write(i, 64'd0);
    cfg_write(7, {32'(ONE), 32'd0});
    send_query(mk_query(fvc_pkg::CMD_SPHERE, 5 * ONE, -7 * ONE, 0, 0, 0, 0, 0));
    send_query(mk_query(fvc_pkg::CMD_BOX, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0));
    cfg_write(7, {32'(-ONE), 32'd0});
    send_query(mk_query(fvc_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, 31'h7fffffff));
    send_query(mk_query(fvc_pkg::CMD_BOX, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_matrix_extremes();
    logic [63:0] ext [4] = '{64'hffffffff_ffffffff, 64'h7fffffff_80000000,
                             64'h80000000_7fffffff, 64'h7fffffff_7fffffff};
    for (int e = 0; e < 4; e++) begin
      for (int i = 0; i < fvc_pkg::CFG_REGS; i++) cfg_write(i, ext[(e + i) % 4]);
      run_random(6);
    end
  endtask

  task automatic test_ignored_index();
    load_matrix(1'b0);
    cfg_write(fvc_pkg::CFG_REGS, 64'h12345678_9abcdef0);
    cfg_write(15, 64'hffffffff_ffffffff);
    send_query(mk_query(fvc_pkg::CMD_SPHERE, -ONE, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(fvc_pkg::CMD_BOX, 0, 0, 0, 2 * ONE, ONE / 2, ONE / 2, 0));
  endtask

  task automatic test_output_stall();
    tx_idle = 0;
    rx_hold = 1'b1;
    fork
      run_random(60);
      begin
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join
  endtask

  task automatic test_random_streams();
    int tx_pct [3] = '{24, 65, 0};
    int rx_pct [3] = '{65, 24, 0};
    for (int p = 0; p < 3; p++) begin
      tx_idle = tx_pct[p];
      rx_idle = rx_pct[p];
      for (int m = 0; m < 3; m++) begin
        load_matrix(m != 0 || p != 0);
        run_random(205);
      end
    end
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= fvc_pkg::CMD_SPHERE;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    for (int i = 0; i < fvc_pkg::CFG_REGS; i++) matrix_regs[i] = fvc_pkg::CFG_RESET[i];
    rebuild_planes();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_planes();
    test_zero_normal();
    test_matrix_extremes();
    test_ignored_index();
    test_output_stall();
    test_random_streams();
    drain();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fvc_pkg.sv
hw/rtl/fvc_plane_builder.sv
hw/rtl/fvc_query_pipe.sv
hw/rtl/frustum_volume_culling.sv
bench/frustum_volume_culling_tb.sv
